// ===== rtl/hhc_pkg.sv =====
// ----------------------------------------------------------------------------
// hhc_pkg
// Shared widths, hash constants, result codes, table entry layout, state types,
// the saturating counter add and key derivation of the hashed hit count table.
// ----------------------------------------------------------------------------
package hhc_pkg;

   localparam int ADDR_W    = 32;
   localparam int KEY_W     = 32;
   localparam int CNT_W     = 48;
   localparam int WEIGHT_W  = 16;
   localparam int SLOT_W    = 12;
   localparam int OUTCOME_W = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd64;
   localparam logic [CNT_W-1:0]    CNT_MAX      = {CNT_W{1'b1}};

   localparam logic [ADDR_W-1:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [ADDR_W-1:0] HASH_MUL_B = 32'h846ca68b;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT      = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_INSERT   = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } entry_type;

   typedef enum logic [2:0] {
      CORE_CLEAR,
      CORE_IDLE,
      CORE_HASH,
      CORE_PROBE,
      CORE_UPDATE,
      CORE_OVER
   } core_state_type;

   typedef enum logic [2:0] {
      HASH_IDLE,
      HASH_MUL1,
      HASH_MUL2,
      HASH_MIX,
      HASH_MOD
   } hash_state_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [WEIGHT_W-1:0] w);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {{(CNT_W + 1 - WEIGHT_W){1'b0}}, w};
      sat_add = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] make_key(input logic [ADDR_W-1:0] addr);
      logic [KEY_W-1:0] k;
      k = addr + {{(KEY_W - 1){1'b0}}, 1'b1};
      make_key = (k == '0) ? {{(KEY_W - 1){1'b0}}, 1'b1} : k;
   endfunction

endpackage

// ===== rtl/hhc_ram.sv =====
// ----------------------------------------------------------------------------
// hhc_ram
// Generic single-clock memory: one write port, one read port with
// registered read data, valid in the cycle after the read.
// ----------------------------------------------------------------------------
module hhc_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hhc_hash.sv =====
// ----------------------------------------------------------------------------
// hhc_hash
// Start slot unit: xor-shift / multiply mixing hash of address>>2 over
// registered steps, then reduction to a table index. Power-of-two tables
// mask the low bits; other sizes take one 4-bit remainder step a cycle.
// ----------------------------------------------------------------------------
module hhc_hash #(
   parameter int TABLE_SLOTS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hhc_pkg::ADDR_W-1:0]     address,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

   import hhc_pkg::*;

   localparam int  IDX_W   = $clog2(TABLE_SLOTS);
   localparam int  WIDE_W  = IDX_W + 4;
   localparam int  DIGITS  = ADDR_W / 4;
   localparam int  DIG_W   = $clog2(DIGITS);
   localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [WIDE_W-1:0] SLOTS_WIDE = WIDE_W'(TABLE_SLOTS);

   function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
                                                 input logic [3:0] digit);
      logic [WIDE_W-1:0] t;
      t = {rem, digit};
      for (int i = 3; i >= 0; i--) begin
         if (t >= (SLOTS_WIDE << i)) begin
            t = t - (SLOTS_WIDE << i);
         end
      end
      mod_step = t[IDX_W-1:0];
   endfunction

   hash_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   mix_ff, mix_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [DIG_W-1:0]    dig_ff, dig_in;
   logic                done_ff, done_in;

   logic [ADDR_W-1:0]   shifted;
   logic [ADDR_W-1:0]   pre_mul;
   logic [ADDR_W-1:0]   fin;
   logic [ADDR_W-1:0]   mul_a;
   logic [ADDR_W-1:0]   mul_b;
   logic [ADDR_W-1:0]   product;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HASH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff <= mix_in;
      rem_ff <= rem_in;
      dig_ff <= dig_in;
   end

   // one shared multiplier for both mixing rounds
   always_comb begin
      shifted = address >> 2;
      pre_mul = mix_ff ^ (mix_ff >> 15);
      fin     = mix_ff ^ (mix_ff >> 16);
      mul_a   = (state_ff == HASH_MUL1) ? mix_ff : pre_mul;
      mul_b   = (state_ff == HASH_MUL1) ? HASH_MUL_A : HASH_MUL_B;
      product = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      mix_in   = mix_ff;
      rem_in   = rem_ff;
      dig_in   = dig_ff;
      done_in  = 1'b0;
      case (state_ff)
         HASH_IDLE: begin
            if (start) begin
               mix_in   = shifted ^ (shifted >> 16);
               state_in = HASH_MUL1;
            end
         end
         HASH_MUL1: begin
            mix_in   = product[ADDR_W-1:0];
            state_in = HASH_MUL2;
         end
         HASH_MUL2: begin
            mix_in   = product[ADDR_W-1:0];
            state_in = HASH_MIX;
         end
         HASH_MIX: begin
            if (IS_POW2) begin
               rem_in   = fin[IDX_W-1:0];
               done_in  = 1'b1;
               state_in = HASH_IDLE;
            end else begin
               mix_in   = fin;
               rem_in   = '0;
               dig_in   = '0;
               state_in = HASH_MOD;
            end
         end
         HASH_MOD: begin
            rem_in = mod_step(rem_ff, mix_ff[ADDR_W-1 -: 4]);
            mix_in = mix_ff << 4;
            dig_in = dig_ff + 1'b1;
            if (dig_ff == DIG_W'(DIGITS - 1)) begin
               done_in  = 1'b1;
               state_in = HASH_IDLE;
            end
         end
         default: begin
            state_in = HASH_IDLE;
         end
      endcase
   end

   assign done = done_ff;
   assign slot = rem_ff;

endmodule

// ===== rtl/hashed_hit_count_table_core.sv =====
// Flow: an accepted item is keyed and hashed (mixing, then remainder steps
// when TABLE_SLOTS is not a power of two), its probe reads are checked in
// turn until a hit or empty slot settles it (UPDATE) or PROBES checks miss
// (OVER). The core takes no new item until the result is registered; req_stall
// is high outside idle. Reset (synchronous): counters clear, weight 64,
// then a clearing pass over every table slot with req_stall high.
// ----------------------------------------------------------------------------
// hashed_hit_count_table_core
// Weighted hit counter over an open-addressed table with linear probing.
// Keys and counts share one memory; probes stream one read per cycle and
// the settling slot is written back with its saturated count.
// ----------------------------------------------------------------------------
module hashed_hit_count_table_core #(
   parameter int TABLE_SLOTS = 4096,
   parameter int PROBES      = 8
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hhc_pkg::ADDR_W-1:0]        req_address,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hhc_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [hhc_pkg::OUTCOME_W-1:0]     rsp_outcome,
   output logic [hhc_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic [hhc_pkg::CNT_W-1:0]         rsp_total_samples,
   output logic [hhc_pkg::CNT_W-1:0]         rsp_overflow_samples,

   input  logic                              csr_wr_en,
   input  logic [hhc_pkg::WEIGHT_W-1:0]      csr_wr_data
);

   import hhc_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_SLOTS);
   localparam int PCNT_W  = $clog2(PROBES + 1);
   localparam int ENTRY_W = $bits(entry_type);
   localparam int EXT_W   = IDX_W + SLOT_W;

   core_state_type        state_ff, state_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [PCNT_W-1:0]     issued_ff, issued_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [PCNT_W-1:0]     chk_num_ff, chk_num_in;
   logic [IDX_W-1:0]      upd_slot_ff, upd_slot_in;
   logic                  upd_hit_ff, upd_hit_in;
   logic [CNT_W-1:0]      upd_old_ff, upd_old_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      over_ff, over_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]      rsp_over_ff, rsp_over_in;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   entry_type             ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   entry_type             ram_rd_data;

   logic                  hash_start;
   logic                  hash_done;
   logic [IDX_W-1:0]      hash_slot;

   logic                  accept;
   logic                  rsp_take;
   logic                  out_free;
   logic                  issue;
   logic                  key_hit;
   logic                  key_empty;
   logic                  last_chk;
   logic [CNT_W-1:0]      new_count;
   logic [CNT_W-1:0]      new_total;
   logic [CNT_W-1:0]      new_over;
   logic [EXT_W-1:0]      slot_ext;

   hhc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hhc_hash #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .address (req_address),
      .done    (hash_done),
      .slot    (hash_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CORE_CLEAR;
         weight_ff    <= WEIGHT_RESET;
         clr_idx_ff   <= '0;
         issued_ff    <= '0;
         chk_valid_ff <= 1'b0;
         chk_num_ff   <= '0;
         total_ff     <= '0;
         over_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         clr_idx_ff   <= clr_idx_in;
         issued_ff    <= issued_in;
         chk_valid_ff <= chk_valid_in;
         chk_num_ff   <= chk_num_in;
         total_ff     <= total_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      rd_idx_ff      <= rd_idx_in;
      chk_idx_ff     <= chk_idx_in;
      upd_slot_ff    <= upd_slot_in;
      upd_hit_ff     <= upd_hit_in;
      upd_old_ff     <= upd_old_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_over_ff    <= rsp_over_in;
   end

   always_comb begin
      accept    = req_valid && (state_ff == CORE_IDLE);
      rsp_take  = rsp_valid_ff && !rsp_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      issue     = issued_ff != PCNT_W'(PROBES);
      key_hit   = ram_rd_data.key == key_ff;
      key_empty = ram_rd_data.key == '0;
      last_chk  = chk_num_ff == PCNT_W'(PROBES - 1);
      new_count = sat_add(upd_old_ff, weight_ff);
      new_total = sat_add(total_ff, weight_ff);
      new_over  = sat_add(over_ff, weight_ff);
      slot_ext  = EXT_W'(upd_slot_ff);
   end

   always_comb begin
      state_in       = state_ff;
      weight_in      = csr_wr_en ? csr_wr_data : weight_ff;
      key_in         = key_ff;
      clr_idx_in     = clr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      issued_in      = issued_ff;
      chk_valid_in   = chk_valid_ff;
      chk_idx_in     = chk_idx_ff;
      chk_num_in     = chk_num_ff;
      upd_slot_in    = upd_slot_ff;
      upd_hit_in     = upd_hit_ff;
      upd_old_in     = upd_old_ff;
      total_in       = total_ff;
      over_in        = over_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_slot_in    = rsp_slot_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_over_in    = rsp_over_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = upd_slot_ff;
      ram_wr_data    = '{key: key_ff, count: new_count};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_idx_ff;
      hash_start     = 1'b0;
      req_stall      = state_ff != CORE_IDLE;

      case (state_ff)
         CORE_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = CORE_IDLE;
            end
         end
         CORE_IDLE: begin
            if (accept) begin
               hash_start = 1'b1;
               key_in     = make_key(req_address);
               state_in   = CORE_HASH;
            end
         end
         CORE_HASH: begin
            if (hash_done) begin
               rd_idx_in    = hash_slot;
               issued_in    = '0;
               chk_valid_in = 1'b0;
               chk_num_in   = '0;
               state_in     = CORE_PROBE;
            end
         end
         CORE_PROBE: begin
            // reads stream one slot a cycle, data is checked in the cycle after its read
            ram_rd_en    = issue;
            chk_valid_in = issue;
            chk_idx_in   = rd_idx_ff;
            if (issue) begin
               issued_in = issued_ff + 1'b1;
               rd_idx_in = (rd_idx_ff == IDX_W'(TABLE_SLOTS - 1)) ? '0 : rd_idx_ff + 1'b1;
            end
            if (chk_valid_ff) begin
               chk_num_in = chk_num_ff + 1'b1;
               if (key_hit || key_empty) begin
                  upd_slot_in = chk_idx_ff;
                  upd_hit_in  = key_hit;
                  upd_old_in  = ram_rd_data.count;
                  state_in    = CORE_UPDATE;
               end else if (last_chk) begin
                  state_in = CORE_OVER;
               end
            end
         end
         CORE_UPDATE: begin
            if (out_free) begin
               ram_wr_en      = 1'b1;
               total_in       = new_total;
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = slot_ext[SLOT_W-1:0];
               rsp_outcome_in = upd_hit_ff ? OUTCOME_HIT : OUTCOME_INSERT;
               rsp_count_in   = new_count;
               rsp_total_in   = new_total;
               rsp_over_in    = over_ff;
               state_in       = CORE_IDLE;
            end
         end
         CORE_OVER: begin
            if (out_free) begin
               total_in       = new_total;
               over_in        = new_over;
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = '0;
               rsp_outcome_in = OUTCOME_OVERFLOW;
               rsp_count_in   = '0;
               rsp_total_in   = new_total;
               rsp_over_in    = new_over;
               state_in       = CORE_IDLE;
            end
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_total_samples    = rsp_total_ff;
   assign rsp_overflow_samples = rsp_over_ff;

`ifndef SYNTH
   a_total_covers_overflow: assert property (@(posedge clock) disable iff (reset)
      total_ff >= over_ff)
      else $error("overflow total above running total");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == CORE_HASH)
      else $error("start slot arrived outside hash wait");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORE_PROBE) |-> issued_ff <= PCNT_W'(PROBES))
      else $error("more probe reads than allowed");

   a_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      accept |=> key_ff != '0)
      else $error("zero key taken for an item");
`endif

endmodule

// ===== tb/hashed_hit_count_table_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_hit_count_table_core_tb
// Drives sampled addresses into the hit count table and checks every result
// against a local model of the hashed table, its probe walk and its
// saturating totals. Covers key wrap, zero weight, probe overflow through
// colliding address clusters, a long receiver hold-off and random traffic
// under several sample weights.
// ----------------------------------------------------------------------------
module hashed_hit_count_table_core_tb;

   import hhc_pkg::*;

   localparam int          TABLE_SLOTS    = 4096;
   localparam int          PROBES         = 8;
   localparam logic [31:0] SLOT_COUNT     = 32'd4096;
   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          PHASE_ITEMS    = 220;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic [OUTCOME_W-1:0] outcome;
      logic [CNT_W-1:0]     entry_count;
      logic [CNT_W-1:0]     total_samples;
      logic [CNT_W-1:0]     overflow_samples;
   } hit_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ADDR_W-1:0]    req_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [OUTCOME_W-1:0] rsp_outcome;
   logic [CNT_W-1:0]     rsp_entry_count;
   logic [CNT_W-1:0]     rsp_total_samples;
   logic [CNT_W-1:0]     rsp_overflow_samples;
   logic                 csr_wr_en = 1'b0;
   logic [WEIGHT_W-1:0]  csr_wr_data = '0;

   // table model
   logic [KEY_W-1:0]     model_keys [TABLE_SLOTS];
   logic [CNT_W-1:0]     model_counts [TABLE_SLOTS];
   logic [CNT_W-1:0]     model_total;
   logic [CNT_W-1:0]     model_overflow;
   logic [WEIGHT_W-1:0]  model_weight;

   hit_result_type       pending_results [$];
   logic [ADDR_W-1:0]    hot_addresses [$];
   logic [ADDR_W-1:0]    crowded_addresses [$];

   int                   mismatch_count = 0;
   int                   results_seen = 0;
   int                   stuck_cycles = 0;
   bit                   calm = 1'b0;
   bit                   hold_request = 1'b0;

   hashed_hit_count_table_core #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .PROBES      (PROBES)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_address          (req_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_slot             (rsp_slot),
      .rsp_outcome          (rsp_outcome),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_total_samples    (rsp_total_samples),
      .rsp_overflow_samples (rsp_overflow_samples),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] count,
                                                    input logic [WEIGHT_W-1:0] weight);
      logic [CNT_W:0] sum;
      sum = {1'b0, count} + {{(CNT_W + 1 - WEIGHT_W){1'b0}}, weight};
      return (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
   endfunction

   function automatic logic [31:0] start_slot(input logic [ADDR_W-1:0] address);
      logic [31:0] v;
      v = address >> 2;
      v = v ^ (v >> 16);
      v = v * HASH_MUL_A;
      v = v ^ (v >> 15);
      v = v * HASH_MUL_B;
      v = v ^ (v >> 16);
      return v % SLOT_COUNT;
   endfunction

   function automatic hit_result_type record_sample(input logic [ADDR_W-1:0] address);
      logic [KEY_W-1:0] key;
      logic [31:0]      first;
      logic [31:0]      idx;
      hit_result_type   res;
      bit               placed;
      key = address + 32'd1;
      if (key == '0) key = 32'd1;
      first = start_slot(address);
      model_total = add_clamped(model_total, model_weight);
      res.slot = '0;
      res.outcome = OUTCOME_OVERFLOW;
      res.entry_count = '0;
      placed = 1'b0;
      for (int p = 0; p < PROBES; p++) begin
         idx = (first + 32'(p)) % SLOT_COUNT;
         if (!placed && (model_keys[idx] == key || model_keys[idx] == '0)) begin
            res.outcome = (model_keys[idx] == key) ? OUTCOME_HIT : OUTCOME_INSERT;
            model_keys[idx] = key;
            model_counts[idx] = add_clamped(model_counts[idx], model_weight);
            res.slot = idx[SLOT_W-1:0];
            res.entry_count = model_counts[idx];
            placed = 1'b1;
         end
      end
      if (!placed) model_overflow = add_clamped(model_overflow, model_weight);
      res.total_samples = model_total;
      res.overflow_samples = model_overflow;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return hot_addresses[$urandom_range(hot_addresses.size() - 1)];
      if (roll < 70) return crowded_addresses[$urandom_range(crowded_addresses.size() - 1)];
      if (roll < 90) return $urandom();
      case ($urandom_range(4))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return hot_addresses[$urandom_range(hot_addresses.size() - 1)] ^
                   32'($urandom_range(1, 3));
         3: return 32'h8000_0000 | 32'($urandom_range(3));
         default: return 32'h7fff_fffc | 32'($urandom_range(3));
      endcase
   endfunction

   // clusters of addresses that share one start slot, three hash groups each
   task automatic gather_crowded_addresses();
      logic [31:0] seed;
      logic [31:0] target;
      logic [31:0] candidate;
      int          groups;
      for (int c = 0; c < 4; c++) begin
         seed = $urandom() & ~32'd3;
         target = start_slot(seed);
         candidate = seed;
         groups = 0;
         while (groups < 3) begin
            if (start_slot(candidate) == target) begin
               for (int j = 0; j < 4; j++)
                  crowded_addresses = {crowded_addresses, candidate + 32'(j)};
               groups++;
            end
            candidate = candidate + 32'd4;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [CNT_W-1:0] wanted,
                                  input logic [CNT_W-1:0] got);
      if (mismatch_count < 50)
         $display("error: result %0d %s expected %h got %h", results_seen, what, wanted, got);
      mismatch_count++;
   endtask

   task automatic offer_address(input logic [ADDR_W-1:0] address);
      @(negedge clock);
      if (!calm) begin
         while ($urandom_range(99) < 23) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_address <= address;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results = {pending_results, record_sample(address)};
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_sample_weight(input logic [WEIGHT_W-1:0] weight);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= weight;
      @(posedge clock);
      model_weight = weight;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_key_wrap_and_extremes();
      offer_address(32'h0000_0000);
      offer_address(32'hffff_ffff);
      offer_address(32'hffff_fffe);
      offer_address(32'h7fff_ffff);
      offer_address(32'h8000_0000);
      offer_address(32'h0000_0004);
      offer_address(32'h0000_0000);
      offer_address(32'hffff_ffff);
      wait_for_results();
   endtask

   task automatic test_zero_weight();
      write_sample_weight(16'd0);
      offer_address(32'h1234_5678);
      offer_address(32'h1234_5678);
      offer_address(32'h0000_0000);
      wait_for_results();
   endtask

   task automatic test_probe_overflow();
      gather_crowded_addresses();
      write_sample_weight(16'd1);
      for (int i = 0; i < 12; i++) offer_address(crowded_addresses[i]);
      wait_for_results();
   endtask

   task automatic test_stalled_receiver();
      write_sample_weight(16'hffff);
      calm = 1'b1;
      hold_request = 1'b1;
      repeat (40) offer_address($urandom());
      wait_for_results();
      calm = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [WEIGHT_W-1:0] weights [5];
      weights[0] = 16'hffff;
      weights[1] = 16'd1;
      weights[2] = 16'($urandom_range(2, 65534));
      weights[3] = 16'd0;
      weights[4] = 16'($urandom());
      repeat (32) hot_addresses = {hot_addresses, $urandom()};
      for (int ph = 0; ph < 5; ph++) begin
         write_sample_weight(weights[ph]);
         calm = (ph == 2);
         repeat (PHASE_ITEMS) offer_address(pick_address());
         wait_for_results();
         calm = 1'b0;
      end
   endtask

   // receiver stalls
   always @(negedge clock) begin : drive_rsp_stall
      static int hold_left = 0;
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 23);
      end
   end

   always @(posedge clock) begin : check_results
      hit_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected, slot", '0, CNT_W'(rsp_slot));
         end else begin
            want = pending_results.pop_front();
            if (rsp_slot !== want.slot)
               report_mismatch("slot", CNT_W'(want.slot), CNT_W'(rsp_slot));
            if (rsp_outcome !== want.outcome)
               report_mismatch("outcome", CNT_W'(want.outcome), CNT_W'(rsp_outcome));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", want.entry_count, rsp_entry_count);
            if (rsp_total_samples !== want.total_samples)
               report_mismatch("total_samples", want.total_samples, rsp_total_samples);
            if (rsp_overflow_samples !== want.overflow_samples)
               report_mismatch("overflow_samples", want.overflow_samples,
                               rsp_overflow_samples);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         model_keys[i] = '0;
         model_counts[i] = '0;
      end
      model_total = '0;
      model_overflow = '0;
      model_weight = WEIGHT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_key_wrap_and_extremes();
      test_zero_weight();
      test_probe_overflow();
      test_stalled_receiver();
      test_random_traffic();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
